### sv/aiex_pkg.sv
// ----------------------------------------------------------------------------
// aiex_pkg
// shared types, field widths and condition logic for the integer execute unit
// ----------------------------------------------------------------------------
package aiex_pkg;

    // instruction kinds carried on the input tuser
    typedef enum logic [4:0] {
        KIND_ADD   = 5'd0,
        KIND_SUB   = 5'd1,
        KIND_ADDS  = 5'd2,
        KIND_SUBS  = 5'd3,
        KIND_AND   = 5'd4,
        KIND_ORR   = 5'd5,
        KIND_EOR   = 5'd6,
        KIND_ANDS  = 5'd7,
        KIND_MOV   = 5'd8,
        KIND_MOVK  = 5'd9,
        KIND_B     = 5'd10,
        KIND_BL    = 5'd11,
        KIND_BR    = 5'd12,
        KIND_BLR   = 5'd13,
        KIND_CBZ   = 5'd14,
        KIND_CBNZ  = 5'd15,
        KIND_BCOND = 5'd16,
        KIND_NOP   = 5'd17
    } kind_t;

    // condition code pairs, selected by cond[3:1]
    typedef enum logic [2:0] {
        CB_EQ = 3'd0,
        CB_CS = 3'd1,
        CB_MI = 3'd2,
        CB_VS = 3'd3,
        CB_HI = 3'd4,
        CB_GE = 3'd5,
        CB_GT = 3'd6,
        CB_AL = 3'd7
    } cond_base_t;

    // nzcv bit positions
    localparam int unsigned FLAG_N = 3;
    localparam int unsigned FLAG_Z = 2;
    localparam int unsigned FLAG_C = 1;
    localparam int unsigned FLAG_V = 0;

    localparam int unsigned XLEN       = 64;
    localparam int unsigned KIND_W     = 5;
    localparam int unsigned REG_W      = 5;
    localparam int unsigned SHIFT_W    = 6;
    localparam int unsigned COND_W     = 4;
    localparam int unsigned FLAGS_W    = 4;
    localparam int unsigned HALF_W     = 16;
    localparam int unsigned IN_DATA_W  = 336;
    localparam int unsigned OUT_DATA_W = 144;
    localparam int unsigned OUT_USER_W = 3;

    typedef logic [XLEN-1:0]    xword_t;
    typedef logic [FLAGS_W-1:0] nzcv_t;

    // aarch64 condition check against the nzcv flags
    function automatic logic cond_holds(input logic [COND_W-1:0] cond, input nzcv_t f);
        logic       t;
        cond_base_t base;
        base = cond_base_t'(cond[3:1]);
        t    = 1'b0;
        unique case (base)
            CB_EQ: t = f[FLAG_Z];
            CB_CS: t = f[FLAG_C];
            CB_MI: t = f[FLAG_N];
            CB_VS: t = f[FLAG_V];
            CB_HI: t = f[FLAG_C] & ~f[FLAG_Z];
            CB_GE: t = (f[FLAG_N] == f[FLAG_V]);
            CB_GT: t = (f[FLAG_N] == f[FLAG_V]) & ~f[FLAG_Z];
            CB_AL: t = 1'b1;
            default: t = 1'b1;
        endcase
        // al and nv are both always taken, other odd codes invert
        if (base != CB_AL && cond[0])
        begin
            t = ~t;
        end
        return t;
    endfunction

endpackage

### sv/aarch64_integer_execute_unit.sv
// ----------------------------------------------------------------------------
// aarch64_integer_execute_unit
// executes one decoded aarch64 integer or branch instruction per transaction
// and keeps the nzcv flags
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               contents
//  s_axis    in         s_axis_tvalid/tready    decoded instruction, kind on tuser
//  m_axis    out        m_axis_tvalid/tready    write-back, branch and flag result
//
//  one instruction per cycle sustained while the result side is not stalled; an
//  input transaction passes through an input register, then the alu/branch
//  logic into the result register
//  the flags register is updated when an instruction moves into the result
//  register, so a following b.cond sees flags of all older instructions
//  rst_n clears the valid bits and the flags; payload registers are not reset
//  a stalled result holds the input register; the input side keeps accepting
//  while the result register drains in the same cycle
//
module aarch64_integer_execute_unit
    import aiex_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // operand_a[63:0], operand_b[127:64], old_dest[191:128], dest_reg[196:192],
    // shift[202:197], cond[206:203], target[270:207], next_pc[334:271], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind[4:0]
    input  logic [KIND_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // write_index[4:0], reg_value[68:5], new_pc[132:69], flags_out[136:133],
    // zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // reg_write[0], link_write[1], pc_write[2]
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    // input stage
    logic                 in_valid_reg;
    logic [IN_DATA_W-1:0] in_data_reg;
    logic [KIND_W-1:0]    in_kind_reg;

    // result stage
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_USER_W-1:0] out_user_reg;

    nzcv_t flags_reg;
    nzcv_t flags_next;

    logic advance;
    logic set_flags;

    // unpacked fields of the held instruction
    xword_t              op_a;
    xword_t              op_b;
    xword_t              old_dest;
    logic [REG_W-1:0]    dest_reg;
    logic [SHIFT_W-1:0]  shift;
    logic [COND_W-1:0]   cond;
    xword_t              target;
    xword_t              next_pc;

    // datapath
    logic       is_sub;
    xword_t     b_op;
    logic [XLEN:0] sum;
    xword_t     alu_res;
    xword_t     logic_and;
    xword_t     movk_mask;
    xword_t     movk_ins;
    logic       reg_write;
    logic       link_write;
    logic       pc_write;
    xword_t     reg_value;
    xword_t     new_pc;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic [OUT_USER_W-1:0] out_user_next;

    assign op_a     = in_data_reg[63:0];
    assign op_b     = in_data_reg[127:64];
    assign old_dest = in_data_reg[191:128];
    assign dest_reg = in_data_reg[196:192];
    assign shift    = in_data_reg[202:197];
    assign cond     = in_data_reg[206:203];
    assign target   = in_data_reg[270:207];
    assign next_pc  = in_data_reg[334:271];

    // the held instruction moves on when the result register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // shared adder; subtraction as a + ~b + 1, carry out is not-borrow
    assign is_sub    = (in_kind_reg == KIND_SUB) || (in_kind_reg == KIND_SUBS);
    assign b_op      = is_sub ? ~op_b : op_b;
    assign sum       = {1'b0, op_a} + {1'b0, b_op} + {{XLEN{1'b0}}, is_sub};
    assign alu_res   = sum[XLEN-1:0];
    assign logic_and = op_a & op_b;

    // movk places 16 bits at one of four half-word lanes
    always_comb
    begin
        movk_mask = '0;
        movk_ins  = '0;
        unique case (shift[5:4])
            2'd0:
            begin
                movk_mask[15:0] = '1;
                movk_ins[15:0]  = op_b[15:0];
            end
            2'd1:
            begin
                movk_mask[31:16] = '1;
                movk_ins[31:16]  = op_b[15:0];
            end
            2'd2:
            begin
                movk_mask[47:32] = '1;
                movk_ins[47:32]  = op_b[15:0];
            end
            2'd3:
            begin
                movk_mask[63:48] = '1;
                movk_ins[63:48]  = op_b[15:0];
            end
            default:
            begin
                movk_mask = '0;
                movk_ins  = '0;
            end
        endcase
    end

    always_comb
    begin
        reg_write  = 1'b0;
        link_write = 1'b0;
        pc_write   = 1'b0;
        reg_value  = '0;
        new_pc     = '0;
        set_flags  = 1'b0;
        flags_next = flags_reg;
        unique case (in_kind_reg)
            KIND_ADD, KIND_SUB:
            begin
                reg_write = 1'b1;
                reg_value = alu_res;
            end
            KIND_ADDS, KIND_SUBS:
            begin
                reg_write          = 1'b1;
                reg_value          = alu_res;
                set_flags          = 1'b1;
                flags_next[FLAG_N] = alu_res[XLEN-1];
                flags_next[FLAG_Z] = (alu_res == '0);
                flags_next[FLAG_C] = sum[XLEN];
                // overflow: operands of equal sign give a result of the other sign
                flags_next[FLAG_V] = (op_a[XLEN-1] == b_op[XLEN-1])
                                   && (alu_res[XLEN-1] != op_a[XLEN-1]);
            end
            KIND_AND:
            begin
                reg_write = 1'b1;
                reg_value = logic_and;
            end
            KIND_ORR:
            begin
                reg_write = 1'b1;
                reg_value = op_a | op_b;
            end
            KIND_EOR:
            begin
                reg_write = 1'b1;
                reg_value = op_a ^ op_b;
            end
            KIND_ANDS:
            begin
                reg_write          = 1'b1;
                reg_value          = logic_and;
                set_flags          = 1'b1;
                flags_next[FLAG_N] = logic_and[XLEN-1];
                flags_next[FLAG_Z] = (logic_and == '0);
                flags_next[FLAG_C] = 1'b0;
                flags_next[FLAG_V] = 1'b0;
            end
            KIND_MOV:
            begin
                reg_write = 1'b1;
                reg_value = op_b;
            end
            KIND_MOVK:
            begin
                reg_write = 1'b1;
                reg_value = (old_dest & ~movk_mask) | movk_ins;
            end
            KIND_B:
            begin
                pc_write = 1'b1;
                new_pc   = target;
            end
            KIND_BL:
            begin
                pc_write   = 1'b1;
                link_write = 1'b1;
                new_pc     = target;
            end
            KIND_BR:
            begin
                pc_write = 1'b1;
                new_pc   = op_a;
            end
            KIND_BLR:
            begin
                pc_write   = 1'b1;
                link_write = 1'b1;
                new_pc     = op_a;
            end
            KIND_CBZ:
            begin
                pc_write = 1'b1;
                new_pc   = (op_a == '0) ? target : next_pc;
            end
            KIND_CBNZ:
            begin
                pc_write = 1'b1;
                new_pc   = (op_a != '0) ? target : next_pc;
            end
            KIND_BCOND:
            begin
                // tests flags left by older instructions
                pc_write = 1'b1;
                new_pc   = cond_holds(cond, flags_reg) ? target : next_pc;
            end
            default:
            begin
                // nop and unused kinds give an empty result
                reg_write = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_data_next          = '0;
        out_data_next[4:0]     = reg_write ? dest_reg : '0;
        out_data_next[68:5]    = reg_value;
        out_data_next[132:69]  = new_pc;
        out_data_next[136:133] = flags_next;
        out_user_next          = {pc_write, link_write, reg_write};
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
            in_kind_reg <= s_axis_tuser;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // flags only move when a flag-setting instruction enters the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && set_flags) |=> $stable(flags_reg))
        else $error("nzcv changed without a flag-setting instruction");

    // a held instruction is not overwritten while the result side stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)
                                        && $stable(in_kind_reg)))
        else $error("input stage lost an instruction under stall");

    // a result never writes a register and the pc at once; link only with a branch
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (!(m_axis_tuser[0] && m_axis_tuser[2])
                           && (!m_axis_tuser[1] || m_axis_tuser[2])))
        else $error("inconsistent write flags on result");

    // the result register reports the flags held after its instruction
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (m_axis_tdata[136:133] == flags_reg))
        else $error("flags_out differs from the flags register");

endmodule
